>>> rtl/itaf_pkg.sv
package itaf_pkg;

  // Default sizes.
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int VALUE_BITS_DEF = 64;

  // Conversion kinds.
  localparam logic [2:0] FUNC_SDEC = 3'd0;
  localparam logic [2:0] FUNC_UDEC = 3'd1;
  localparam logic [2:0] FUNC_OCT  = 3'd2;
  localparam logic [2:0] FUNC_HEXL = 3'd3;
  localparam logic [2:0] FUNC_HEXU = 3'd4;
  localparam logic [2:0] FUNC_PTR  = 3'd5;

  // Flag bit positions.
  localparam int FL_ALT   = 0;
  localparam int FL_ZPAD  = 1;
  localparam int FL_LADJ  = 2;
  localparam int FL_SPACE = 3;
  localparam int FL_PLUS  = 4;

  // Characters.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_NORM,
    S_PLAN,
    S_PRE,
    S_LEAD,
    S_ZERO,
    S_DIGIT,
    S_POST
  } state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = (upper ? CH_UP_A : CH_LOW_A) + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> rtl/integer_to_ascii_formatter.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | func, value, flags, field_width
// out     | output    | out_valid / out_stall | char_out, last
//
// One item at a time. Decimal kinds pass through a load step, bit-serial binary-to-BCD
// conversion, leading-zero stripping (one digit a cycle) and a planning step; octal and
// hex skip the conversion. Then one character leaves per cycle while the output is not
// stalled, up to MAX_WIDTH characters.
// Reset clears the sequencer and the output valid flag; no clearing pass is needed.
// A stall on the output holds the sequencer in place; in_stall is high while an item is busy.
module integer_to_ascii_formatter #(
  parameter int MAX_WIDTH  = itaf_pkg::MAX_WIDTH_DEF,
  parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [63:0] value,
  input  logic [4:0]  flags,
  input  logic [6:0]  field_width,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_out,
  output logic        last
);

  localparam int NDIG = (VALUE_BITS + 2) / 3;
  localparam int BUFW = NDIG * 4;
  localparam int DW   = $clog2(NDIG + 1);
  localparam int BW   = $clog2(VALUE_BITS + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);

  itaf_pkg::state_t state, state_next;

  logic                  out_valid_next;
  logic [VALUE_BITS-1:0] mag, mag_next;
  logic [BUFW-1:0]       dig_buf, dig_buf_next;
  logic [DW-1:0]         dig_len, dig_len_next;
  logic [BW-1:0]         bit_cnt, bit_cnt_next;
  logic [WW-1:0]         width_r, width_next;
  logic [WW-1:0]         pad_cnt, pad_cnt_next;
  logic [15:0]           lead, lead_next;
  logic [1:0]            lead_len, lead_len_next;
  logic                  zpad, zpad_next;
  logic                  ladj, ladj_next;
  logic                  upper, upper_next;
  logic [7:0]            char_next;
  logic                  last_next;

  // Decode of the incoming item.
  logic [VALUE_BITS-1:0] in_v;
  logic [VALUE_BITS-1:0] in_mag;
  logic                  in_nz;
  logic                  in_neg;
  logic                  in_hex;
  logic                  in_oct;
  logic [15:0]           in_lead;
  logic [1:0]            in_lead_len;
  logic [BUFW-1:0]       in_pad;
  logic [BUFW-1:0]       in_buf;
  logic [WW-1:0]         in_width;

  // Per-digit add-3 for the double-dabble step.
  logic [BUFW-1:0]       dd_adj;
  logic [WW-1:0]         n_text;
  logic [WW-1:0]         pad_len;
  logic                  emit;

  assign in_stall = (state != itaf_pkg::S_IDLE);

  always_comb begin
    in_v   = value[VALUE_BITS-1:0];
    in_nz  = (in_v != '0);
    in_neg = (func == itaf_pkg::FUNC_SDEC) && in_v[VALUE_BITS-1];
    in_mag = in_neg ? (VALUE_BITS'(0) - in_v) : in_v;
    in_hex = (func == itaf_pkg::FUNC_HEXL) || (func == itaf_pkg::FUNC_HEXU) ||
             (func == itaf_pkg::FUNC_PTR);
    in_oct = (func == itaf_pkg::FUNC_OCT);
    in_width = (field_width > 7'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(field_width);

    in_lead     = '0;
    in_lead_len = 2'd0;
    if (func == itaf_pkg::FUNC_SDEC) begin
      if (in_neg) begin
        in_lead     = {itaf_pkg::CH_MINUS, 8'd0};
        in_lead_len = 2'd1;
      end else if (flags[itaf_pkg::FL_PLUS]) begin
        in_lead     = {itaf_pkg::CH_PLUS, 8'd0};
        in_lead_len = 2'd1;
      end else if (flags[itaf_pkg::FL_SPACE]) begin
        in_lead     = {itaf_pkg::CH_SPACE, 8'd0};
        in_lead_len = 2'd1;
      end
    end else if ((flags[itaf_pkg::FL_ALT] || func == itaf_pkg::FUNC_PTR) && in_nz) begin
      if (func == itaf_pkg::FUNC_HEXU) begin
        in_lead     = {itaf_pkg::CH_ZERO, itaf_pkg::CH_UP_X};
        in_lead_len = 2'd2;
      end else if (in_hex) begin
        in_lead     = {itaf_pkg::CH_ZERO, itaf_pkg::CH_LOW_X};
        in_lead_len = 2'd2;
      end else if (in_oct) begin
        in_lead     = {itaf_pkg::CH_ZERO, 8'd0};
        in_lead_len = 2'd1;
      end else if (flags[itaf_pkg::FL_PLUS]) begin
        in_lead     = {itaf_pkg::CH_PLUS, 8'd0};
        in_lead_len = 2'd1;
      end else if (flags[itaf_pkg::FL_SPACE]) begin
        in_lead     = {itaf_pkg::CH_SPACE, 8'd0};
        in_lead_len = 2'd1;
      end
    end

    // Octal and hex digits are plain bit groups of the value.
    in_pad = BUFW'(in_mag);
    in_buf = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (in_hex) begin
        in_buf[4*i +: 4] = in_pad[4*i +: 4];
      end else if (in_oct) begin
        in_buf[4*i +: 4] = {1'b0, in_pad[3*i +: 3]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      dd_adj[4*i +: 4] = (dig_buf[4*i +: 4] >= 4'd5) ? (dig_buf[4*i +: 4] + 4'd3)
                                                       : dig_buf[4*i +: 4];
    end
    n_text  = WW'(dig_len) + WW'(lead_len);
    pad_len = (width_r > n_text) ? (width_r - n_text) : '0;
  end

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    dig_buf_next   = dig_buf;
    dig_len_next   = dig_len;
    bit_cnt_next   = bit_cnt;
    width_next     = width_r;
    pad_cnt_next   = pad_cnt;
    lead_next      = lead;
    lead_len_next  = lead_len;
    zpad_next      = zpad;
    ladj_next      = ladj;
    upper_next     = upper;
    char_next      = char_out;
    last_next      = last;
    emit           = !out_valid || !out_stall;
    out_valid_next = out_valid && out_stall;

    unique case (state)
      itaf_pkg::S_IDLE: begin
        if (in_valid) begin
          mag_next      = in_mag;
          dig_buf_next  = in_buf;
          dig_len_next  = DW'(NDIG);
          bit_cnt_next  = BW'(VALUE_BITS);
          width_next    = in_width;
          lead_next     = in_lead;
          lead_len_next = in_lead_len;
          zpad_next     = flags[itaf_pkg::FL_ZPAD];
          ladj_next     = flags[itaf_pkg::FL_LADJ];
          upper_next    = (func == itaf_pkg::FUNC_HEXU);
          state_next    = (in_hex || in_oct) ? itaf_pkg::S_NORM : itaf_pkg::S_CONV;
        end
      end
      itaf_pkg::S_CONV: begin
        dig_buf_next = {dd_adj[BUFW-2:0], mag[VALUE_BITS-1]};
        mag_next     = {mag[VALUE_BITS-2:0], 1'b0};
        bit_cnt_next = bit_cnt - 1'b1;
        if (bit_cnt == BW'(1)) begin
          state_next = itaf_pkg::S_NORM;
        end
      end
      itaf_pkg::S_NORM: begin
        // Strip one leading zero digit per cycle, keeping at least one digit.
        if (dig_buf[BUFW-1 -: 4] == 4'd0 && dig_len != DW'(1)) begin
          dig_buf_next = {dig_buf[BUFW-5:0], 4'd0};
          dig_len_next = dig_len - 1'b1;
        end else begin
          state_next = itaf_pkg::S_PLAN;
        end
      end
      itaf_pkg::S_PLAN: begin
        pad_cnt_next = pad_len;
        if (!zpad && !ladj && pad_len != '0) begin
          state_next = itaf_pkg::S_PRE;
        end else if (lead_len != 2'd0) begin
          state_next = itaf_pkg::S_LEAD;
        end else if (zpad && pad_len != '0) begin
          state_next = itaf_pkg::S_ZERO;
        end else begin
          state_next = itaf_pkg::S_DIGIT;
        end
      end
      itaf_pkg::S_PRE: begin
        if (emit) begin
          out_valid_next = 1'b1;
          char_next      = itaf_pkg::CH_SPACE;
          last_next      = 1'b0;
          pad_cnt_next   = pad_cnt - 1'b1;
          if (pad_cnt == WW'(1)) begin
            state_next = (lead_len != 2'd0) ? itaf_pkg::S_LEAD : itaf_pkg::S_DIGIT;
          end
        end
      end
      itaf_pkg::S_LEAD: begin
        if (emit) begin
          out_valid_next = 1'b1;
          char_next      = lead[15:8];
          last_next      = 1'b0;
          lead_next      = {lead[7:0], 8'd0};
          lead_len_next  = lead_len - 1'b1;
          if (lead_len == 2'd1) begin
            state_next = (zpad && pad_cnt != '0) ? itaf_pkg::S_ZERO : itaf_pkg::S_DIGIT;
          end
        end
      end
      itaf_pkg::S_ZERO: begin
        if (emit) begin
          out_valid_next = 1'b1;
          char_next      = itaf_pkg::CH_ZERO;
          last_next      = 1'b0;
          pad_cnt_next   = pad_cnt - 1'b1;
          if (pad_cnt == WW'(1)) begin
            state_next = itaf_pkg::S_DIGIT;
          end
        end
      end
      itaf_pkg::S_DIGIT: begin
        if (emit) begin
          out_valid_next = 1'b1;
          char_next      = itaf_pkg::digit_char(dig_buf[BUFW-1 -: 4], upper);
          last_next      = 1'b0;
          dig_buf_next   = {dig_buf[BUFW-5:0], 4'd0};
          dig_len_next   = dig_len - 1'b1;
          if (dig_len == DW'(1)) begin
            if (!zpad && ladj && pad_cnt != '0) begin
              state_next = itaf_pkg::S_POST;
            end else begin
              last_next  = 1'b1;
              state_next = itaf_pkg::S_IDLE;
            end
          end
        end
      end
      itaf_pkg::S_POST: begin
        if (emit) begin
          out_valid_next = 1'b1;
          char_next      = itaf_pkg::CH_SPACE;
          last_next      = 1'b0;
          pad_cnt_next   = pad_cnt - 1'b1;
          if (pad_cnt == WW'(1)) begin
            last_next  = 1'b1;
            state_next = itaf_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = itaf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= itaf_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mag      <= mag_next;
    dig_buf  <= dig_buf_next;
    dig_len  <= dig_len_next;
    bit_cnt  <= bit_cnt_next;
    width_r  <= width_next;
    pad_cnt  <= pad_cnt_next;
    lead     <= lead_next;
    lead_len <= lead_len_next;
    zpad     <= zpad_next;
    ladj     <= ladj_next;
    upper    <= upper_next;
    char_out <= char_next;
    last     <= last_next;
  end

  // An accepted item always starts work on the next cycle.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != itaf_pkg::S_IDLE)
    else $error("accepted item did not start");

  // The conversion counter never runs out while converting.
  a_conv_cnt: assert property (@(posedge clk) disable iff (rst)
    state == itaf_pkg::S_CONV |-> bit_cnt != '0)
    else $error("conversion counter underflow");

  // Digit output always has a digit left to send.
  a_dig_len: assert property (@(posedge clk) disable iff (rst)
    state == itaf_pkg::S_DIGIT |-> dig_len != '0)
    else $error("digit count underflow");

  // Zero fill only with the zero pad flag; leading spaces only without it or left adjust.
  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    state == itaf_pkg::S_ZERO |-> zpad && pad_cnt != '0)
    else $error("zero fill without zero pad");

  a_pre_fill: assert property (@(posedge clk) disable iff (rst)
    state == itaf_pkg::S_PRE |-> !zpad && !ladj && pad_cnt != '0)
    else $error("leading spaces in wrong mode");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD   = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_REPORTS  = 10;

  // Kinds outside the documented range; they format as unsigned decimal.
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;

  localparam logic [4:0] F_NONE  = 5'd0;
  localparam logic [4:0] F_ALT   = 5'(1 << itaf_pkg::FL_ALT);
  localparam logic [4:0] F_ZPAD  = 5'(1 << itaf_pkg::FL_ZPAD);
  localparam logic [4:0] F_LADJ  = 5'(1 << itaf_pkg::FL_LADJ);
  localparam logic [4:0] F_SPACE = 5'(1 << itaf_pkg::FL_SPACE);
  localparam logic [4:0] F_PLUS  = 5'(1 << itaf_pkg::FL_PLUS);
  localparam logic [4:0] F_ALL   = 5'h1f;

  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] INT_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INT_MAX  = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  func;
  logic [63:0] value;
  logic [4:0]  flags;
  logic [6:0]  field_width;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  char_out;
  logic        last;

  text_char_t text_q[$];
  int  n_items;
  int  n_chars;
  int  n_errors;
  int  idle_cycles;
  bit  no_gaps;
  bit  hold_req;

  integer_to_ascii_formatter u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .value       (value),
    .flags       (flags),
    .field_width (field_width),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_out    (char_out),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Builds the printf-style text of one item and queues its characters.
  function automatic void predict_text(input logic [2:0] f, input logic [63:0] v,
                                       input logic [4:0] fl, input logic [6:0] w);
    logic [7:0]  lead[2];
    logic [7:0]  digs[24];
    logic [7:0]  text[$];
    logic [63:0] mag;
    logic [63:0] base;
    logic [3:0]  d;
    logic        upper;
    logic        ladj;
    int          lead_len;
    int          dig_len;
    int          width_i;
    int          pad_len;
    int          i;
    width_i = int'(w);
    if (width_i > itaf_pkg::MAX_WIDTH_DEF) width_i = itaf_pkg::MAX_WIDTH_DEF;
    if (f == itaf_pkg::FUNC_OCT) base = 64'd8;
    else if (f == itaf_pkg::FUNC_HEXL || f == itaf_pkg::FUNC_HEXU ||
             f == itaf_pkg::FUNC_PTR) base = 64'd16;
    else base = 64'd10;
    upper = (f == itaf_pkg::FUNC_HEXU);
    ladj = fl[itaf_pkg::FL_LADJ];
    mag = v;
    lead_len = 0;
    if (f == itaf_pkg::FUNC_SDEC) begin
      if (v[63]) begin
        lead[0] = itaf_pkg::CH_MINUS;
        lead_len = 1;
        mag = 64'd0 - v;
      end else if (fl[itaf_pkg::FL_PLUS]) begin
        lead[0] = itaf_pkg::CH_PLUS;
        lead_len = 1;
      end else if (fl[itaf_pkg::FL_SPACE]) begin
        lead[0] = itaf_pkg::CH_SPACE;
        lead_len = 1;
      end
    end else if ((fl[itaf_pkg::FL_ALT] || f == itaf_pkg::FUNC_PTR) && v != 64'd0) begin
      if (f == itaf_pkg::FUNC_HEXU) begin
        lead[0] = itaf_pkg::CH_ZERO;
        lead[1] = itaf_pkg::CH_UP_X;
        lead_len = 2;
      end else if (base == 64'd16) begin
        lead[0] = itaf_pkg::CH_ZERO;
        lead[1] = itaf_pkg::CH_LOW_X;
        lead_len = 2;
      end else if (base == 64'd8) begin
        lead[0] = itaf_pkg::CH_ZERO;
        lead_len = 1;
      end else if (fl[itaf_pkg::FL_PLUS]) begin
        lead[0] = itaf_pkg::CH_PLUS;
        lead_len = 1;
      end else if (fl[itaf_pkg::FL_SPACE]) begin
        lead[0] = itaf_pkg::CH_SPACE;
        lead_len = 1;
      end
    end
    dig_len = 0;
    do begin
      d = 4'(mag % base);
      if (d < 4'd10) digs[dig_len] = itaf_pkg::CH_ZERO + 8'(d);
      else digs[dig_len] = (upper ? itaf_pkg::CH_UP_A : itaf_pkg::CH_LOW_A) + 8'(d) - 8'd10;
      dig_len++;
      mag = mag / base;
    end while (mag != 64'd0 && dig_len < 24);
    pad_len = (width_i > lead_len + dig_len) ? width_i - lead_len - dig_len : 0;
    if (!fl[itaf_pkg::FL_ZPAD] && !ladj) repeat (pad_len) text.push_back(itaf_pkg::CH_SPACE);
    for (i = 0; i < lead_len; i++) text.push_back(lead[i]);
    if (fl[itaf_pkg::FL_ZPAD]) repeat (pad_len) text.push_back(itaf_pkg::CH_ZERO);
    for (i = dig_len - 1; i >= 0; i--) text.push_back(digs[i]);
    if (!fl[itaf_pkg::FL_ZPAD] && ladj) repeat (pad_len) text.push_back(itaf_pkg::CH_SPACE);
    for (i = 0; i < text.size() && i < itaf_pkg::MAX_WIDTH_DEF; i++) begin
      text_q.push_back('{ch: text[i],
                         last: (i == text.size() - 1 || i == itaf_pkg::MAX_WIDTH_DEF - 1)});
    end
  endfunction

  // Mostly no gap or a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'($urandom_range(1, 20));
      2: return 64'd0 - 64'($urandom_range(1, 20));
      3: begin
        case ($urandom_range(0, 2))
          0: return INT_MIN;
          1: return INT_MAX;
          default: return ALL_ONES;
        endcase
      end
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [2:0] rand_func();
    int r;
    r = $urandom_range(0, 19);
    if (r < 18) return 3'(r % 6);
    return (r == 18) ? FUNC_SPARE6 : FUNC_SPARE7;
  endfunction

  function automatic logic [6:0] rand_width();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 7'($urandom_range(0, 24));
    if (r < 18) return 7'($urandom_range(25, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  function automatic void note_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(input logic [2:0] f, input logic [63:0] v,
                           input logic [4:0] fl, input logic [6:0] w);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func        <= f;
    value       <= v;
    flags       <= fl;
    field_width <= w;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_text(f, v, fl, w);
    n_items++;
  endtask

  // Must be called at the edge where the last item was taken.
  task automatic wait_text_done();
    in_valid <= 1'b0;
    wait (text_q.size() == 0);
  endtask

  task automatic test_signed_directed();
    send_item(itaf_pkg::FUNC_SDEC, 64'd0, F_NONE, 7'd0);
    send_item(itaf_pkg::FUNC_SDEC, 64'd0, F_PLUS, 7'd0);
    send_item(itaf_pkg::FUNC_SDEC, 64'd0, F_SPACE, 7'd0);
    send_item(itaf_pkg::FUNC_SDEC, ALL_ONES, F_NONE, 7'd5);
    send_item(itaf_pkg::FUNC_SDEC, INT_MIN, F_NONE, 7'd0);
    send_item(itaf_pkg::FUNC_SDEC, INT_MAX, F_PLUS, 7'd0);
    send_item(itaf_pkg::FUNC_SDEC, 64'd0 - 64'd42, F_ZPAD, 7'd8);
    send_item(itaf_pkg::FUNC_SDEC, 64'd42, F_ZPAD | F_LADJ | F_PLUS, 7'd8);
    send_item(itaf_pkg::FUNC_SDEC, 64'd7, F_LADJ | F_SPACE, 7'd6);
    send_item(itaf_pkg::FUNC_SDEC, ALL_ONES, F_ALL, 7'd64);
    wait_text_done();
  endtask

  task automatic test_unsigned_directed();
    send_item(itaf_pkg::FUNC_UDEC, ALL_ONES, F_NONE, 7'd0);
    send_item(itaf_pkg::FUNC_UDEC, 64'd5, F_ALT | F_PLUS, 7'd4);
    send_item(itaf_pkg::FUNC_UDEC, 64'd5, F_ALT | F_SPACE, 7'd0);
    send_item(itaf_pkg::FUNC_UDEC, 64'd0, F_ALT | F_PLUS, 7'd3);
    send_item(itaf_pkg::FUNC_OCT, ALL_ONES, F_ALT, 7'd0);
    send_item(itaf_pkg::FUNC_OCT, 64'd0, F_ALT | F_ZPAD, 7'd4);
    send_item(itaf_pkg::FUNC_HEXL, 64'hdead_beef_0123_4567, F_ALT | F_ZPAD, 7'd20);
    send_item(itaf_pkg::FUNC_HEXU, ALL_ONES, F_ALT | F_LADJ, 7'd30);
    send_item(itaf_pkg::FUNC_PTR, 64'd0, F_NONE, 7'd0);
    send_item(itaf_pkg::FUNC_PTR, 64'h1234, F_LADJ, 7'd10);
    send_item(itaf_pkg::FUNC_HEXL, 64'habc, F_NONE, 7'd2);
    send_item(FUNC_SPARE6, 64'd123, F_ALT | F_PLUS, 7'd64);
    send_item(FUNC_SPARE7, 64'd99, F_ALL, 7'd127);
    send_item(itaf_pkg::FUNC_HEXU, 64'hf, F_ZPAD, 7'd100);
    wait_text_done();
  endtask

  task automatic test_random_items(input int count, input bit back_to_back);
    int i;
    no_gaps = back_to_back;
    for (i = 0; i < count; i++) begin
      send_item(rand_func(), rand_value(), 5'($urandom_range(0, 31)), rand_width());
    end
    wait_text_done();
    no_gaps = 1'b0;
  endtask

  // The receiver holds off while items keep coming, so the input side backs up.
  task automatic test_output_hold();
    int i;
    hold_req = 1'b1;
    for (i = 0; i < 16; i++) begin
      send_item(rand_func(), rand_value(), 5'($urandom_range(0, 31)), rand_width());
    end
    wait_text_done();
    wait (!hold_req);
  endtask

  always @(posedge clk) begin : check_chars
    text_char_t exp_c;
    if (!rst && out_valid && !out_stall) begin
      n_chars++;
      if (text_q.size() == 0) begin
        note_error($sformatf("character %h last %b arrived with nothing expected",
                             char_out, last));
      end else begin
        exp_c = text_q.pop_front();
        if (char_out !== exp_c.ch || last !== exp_c.last) begin
          note_error($sformatf("character %0d: expected %h last %b, got %h last %b",
                               n_chars, exp_c.ch, exp_c.last, char_out, last));
        end
      end
    end
  end

  initial begin : drive_out_stall
    int run;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        run = gap_len();
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without a handshake", idle_cycles);
      $display("FAIL integer_to_ascii_formatter");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    n_items     = 0;
    n_chars     = 0;
    n_errors    = 0;
    idle_cycles = 0;
    no_gaps     = 1'b0;
    hold_req    = 1'b0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    func        <= itaf_pkg::FUNC_SDEC;
    value       <= 64'd0;
    flags       <= F_NONE;
    field_width <= 7'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_signed_directed();
    test_unsigned_directed();
    test_random_items(60, 1'b1);
    test_random_items(120, 1'b0);
    test_output_hold();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Formatted %0d items into %0d characters: every conversion kind,", n_items,
             n_chars);
    $display("all flag bits, widths 0 to 127, with and without back-pressure.");
    if (n_errors == 0 && text_q.size() == 0) begin
      $display("PASS integer_to_ascii_formatter");
    end else begin
      $display("%0d mismatches, %0d characters still expected", n_errors, text_q.size());
      $display("FAIL integer_to_ascii_formatter");
    end
    $finish;
  end

endmodule
